// ===== hw/rtl/lcm_pkg.sv =====
// Package for the least-common-multiple unit.
// Holds the transaction payload types, the sequencer state type and sizing constants.
// No dependencies.
package lcm_pkg;

    // Operand range and field widths
    localparam int unsigned OperandWidth  = 17;
    localparam int unsigned MultipleWidth = 32;
    localparam int unsigned ShiftWidth    = 5;
    localparam logic [OperandWidth-1:0] MaxValue = 17'd65536;

    // Restoring divider runs one step per quotient bit
    localparam logic [ShiftWidth-1:0] DivSteps = 5'(OperandWidth);

    typedef struct packed {
        logic [OperandWidth-1:0] left_value;
        logic [OperandWidth-1:0] right_value;
    } t_lcm_req;

    typedef struct packed {
        logic [MultipleWidth-1:0] multiple;
        logic                     range_error;
    } t_lcm_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_lcm_state;

endpackage

// ===== hw/rtl/lcm_req_if.sv =====
// Valid/ready channel carrying one operand pair per transaction.
// Depends on lcm_pkg for the payload type.
interface lcm_req_if import lcm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_lcm_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lcm_rsp_if.sv =====
// Valid/ready channel carrying one LCM result per transaction.
// Depends on lcm_pkg for the payload type.
interface lcm_rsp_if import lcm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_lcm_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lcm_by_prime_factors_unit.sv =====
// Least common multiple of two 17-bit operands, computed iteratively.
// Depends on lcm_pkg, lcm_req_if and lcm_rsp_if.
//
// Usage:
//   i_req carries an operand pair (left_value, right_value), o_rsp carries
//   the result (multiple, range_error). A transaction moves on a rising
//   edge of i_clk with valid and ready both high.
//   The unit works on one pair at a time: i_req.ready is high only while
//   the sequencer is idle. Work runs as a binary GCD (one shift, subtract
//   or swap per cycle on a shared 17-bit subtractor), then a restoring
//   division left/gcd on the same subtractor, then a 17x17 multiply.
//   An operand that is zero or above 65536 skips the arithmetic: the
//   result (0, error set) goes straight to the final state and from
//   there into the output register.
//   The result sits in an output register. If the receiver stalls, the
//   register holds it and the unit still takes the next pair; that pair
//   waits in its final state until the register frees.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and
//   empties the output register.
module lcm_by_prime_factors_unit
    import lcm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcm_req_if.sink       i_req,
    lcm_rsp_if.source     o_rsp
);

    t_lcm_state r_state, n_state;

    logic [OperandWidth-1:0]  r_left;
    logic [OperandWidth-1:0]  r_right;
    logic [OperandWidth-1:0]  r_a;     // GCD operand a, divider remainder
    logic [OperandWidth-1:0]  r_b;     // GCD operand b, divider quotient
    logic [OperandWidth-1:0]  r_g;
    logic [ShiftWidth-1:0]    r_k;
    logic [ShiftWidth-1:0]    r_cnt;
    logic [MultipleWidth-1:0] r_mult;
    logic                     r_err;

    logic                     r_out_valid;
    t_lcm_rsp                 r_out;

    logic                     req_fire;
    logic                     req_bad;
    logic                     load_out;

    logic [OperandWidth-1:0]  div_trial;
    logic [OperandWidth-1:0]  sub_a;
    logic [OperandWidth-1:0]  sub_b;
    logic [OperandWidth:0]    diff;
    logic                     borrow;
    logic                     equal;
    logic [2*OperandWidth-1:0] product;

    // Input checks
    assign req_fire = i_req.valid && i_req.ready;
    assign req_bad  = (i_req.data.left_value == '0) || (i_req.data.right_value == '0) ||
                      (i_req.data.left_value > MaxValue) ||
                      (i_req.data.right_value > MaxValue);

    // Shared subtractor: GCD a-b, or divider trial remainder minus gcd
    assign div_trial = {r_a[OperandWidth-2:0], r_b[OperandWidth-1]};
    always_comb begin
        if (r_state == ST_DIV) begin
            sub_a = div_trial;
            sub_b = r_g;
        end else begin
            sub_a = r_a;
            sub_b = r_b;
        end
    end
    assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow  = diff[OperandWidth];
    assign equal   = (diff == '0);
    assign product = r_b * r_right;

    assign load_out = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) n_state = req_bad ? ST_DONE : ST_GCD;
            end
            ST_GCD: begin
                if (equal) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == 5'd1) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        o_rsp.valid = r_out_valid;
        o_rsp.data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    r_left  <= i_req.data.left_value;
                    r_right <= i_req.data.right_value;
                    r_a     <= i_req.data.left_value;
                    r_b     <= i_req.data.right_value;
                    r_k     <= '0;
                    r_err   <= req_bad;
                    r_mult  <= '0;
                end
            end
            ST_GCD: begin
                priority if (equal) begin
                    // gcd found: restore common powers of two, start divider
                    r_g   <= r_a << r_k;
                    r_a   <= '0;
                    r_b   <= r_left;
                    r_cnt <= DivSteps;
                end else if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + 5'd1;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (!borrow) begin
                    r_a <= diff[OperandWidth-1:0];
                end else begin
                    // keep a as the larger one
                    r_a <= r_b;
                    r_b <= r_a;
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle
                r_a   <= borrow ? div_trial : diff[OperandWidth-1:0];
                r_b   <= {r_b[OperandWidth-2:0], ~borrow};
                r_cnt <= r_cnt - 5'd1;
            end
            ST_MUL: begin
                r_mult <= product[MultipleWidth-1:0];
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.multiple    <= r_mult;
            r_out.range_error <= r_err;
        end
    end

`ifndef SYNTHESIS
    // An error result never carries a value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.range_error) |-> (r_out.multiple == '0))
        else $error("error result with nonzero multiple");

    // GCD operands never reach zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GCD) |-> ((r_a != '0) && (r_b != '0)))
        else $error("zero operand inside GCD loop");

    // The output register is never overwritten while a result is stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_out_valid) |-> o_rsp.ready)
        else $error("output register overwritten while stalled");

    // An accepted transaction always moves to the GCD loop, or to the final state for a bad operand
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state == ST_GCD || r_state == ST_DONE))
        else $error("accepted transaction not started");
`endif

endmodule
